// ===== sv/lcar_pkg.sv =====
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared widths, codes and constants of the load-cell converter reader.
// ----------------------------------------------------------------------------
package lcar_pkg;

   localparam int DATA_BITS     = 24;
   localparam int MAX_SAMPLES   = 64;
   localparam int FRACTION_BITS = 16;

   localparam int SAMPLES_BITS = 7;
   localparam int SCALE_BITS   = 24;
   localparam int FORCE_BITS   = 41;

   localparam int BIT_CNT_BITS = $clog2(DATA_BITS + 1);
   localparam int COUNT_BITS   = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS     = DATA_BITS + $clog2(MAX_SAMPLES + 1);

   // shared divider sizes: average (sum / count) and force (mag * 2^F / scale)
   localparam int DIV_BITS  = (SUM_BITS > DATA_BITS + FRACTION_BITS) ?
                              SUM_BITS : DATA_BITS + FRACTION_BITS;
   localparam int DVSR_BITS = (SCALE_BITS > COUNT_BITS) ? SCALE_BITS : COUNT_BITS;
   localparam int STEP_BITS = $clog2(DIV_BITS + 1);

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = SCALE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLES = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE   = 1'b1;

   localparam logic [SAMPLES_BITS-1:0] SAMPLES_RESET = SAMPLES_BITS'(5);
   localparam logic [SCALE_BITS-1:0]   SCALE_RESET   = SCALE_BITS'(17000);

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_MEASURE = 2'd1,
      MODE_TARE    = 2'd2
   } mode_type;

endpackage

// ===== sv/load_cell_adc_reader.sv =====
// ----------------------------------------------------------------------------
// load_cell_adc_reader
// Host side of the two-wire load-cell converter link with averaging and tare.
// ----------------------------------------------------------------------------
// Each request is one half period of the converter serial clock and gives
// exactly one response. An ordinary tick request is answered in the next
// cycle. The tick that completes a measurement or tare runs the shared
// restoring divider, one quotient bit per cycle over DIV_BITS (40) bits:
// once for the average and, for a measurement, once more for the scaled
// force, before the response is given. One request is in flight at a time;
// req_ready is low until its response has been taken.
module load_cell_adc_reader import lcar_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_data_level,
   input  logic [1:0]                    req_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_serial_clock,
   output logic                          rsp_busy_res,
   output logic                          rsp_result_valid,
   output logic                          rsp_result_kind,
   output logic [DATA_BITS-1:0]          rsp_average_raw,
   output logic signed [FORCE_BITS-1:0]  rsp_force_q16,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   typedef enum logic [1:0] {
      ST_READY,
      ST_AVG,
      ST_FORCE,
      ST_RESP
   } ctrl_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_BITS,
      PH_GAIN
   } phase_type;

   ctrl_type                 state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic                     clock_level_ff, clock_level_in;
   logic [BIT_CNT_BITS-1:0]  bit_counter_ff, bit_counter_in;
   logic [DATA_BITS-1:0]     shift_word_ff, shift_word_in;
   logic [SUM_BITS-1:0]      running_sum_ff, running_sum_in;
   logic [COUNT_BITS-1:0]    words_taken_ff, words_taken_in;
   logic                     pending_kind_ff, pending_kind_in;
   logic [DATA_BITS-1:0]     tare_offset_ff, tare_offset_in;
   logic [SAMPLES_BITS-1:0]  samples_ff, samples_in;
   logic [SCALE_BITS-1:0]    scale_ff, scale_in;
   logic                     neg_ff, neg_in;
   logic [DATA_BITS-1:0]     avg_ff, avg_in;

   logic                     rsp_serial_clock_ff, rsp_serial_clock_in;
   logic                     rsp_busy_res_ff, rsp_busy_res_in;
   logic                     rsp_result_valid_ff, rsp_result_valid_in;
   logic                     rsp_result_kind_ff, rsp_result_kind_in;
   logic [DATA_BITS-1:0]     rsp_average_raw_ff, rsp_average_raw_in;
   logic [FORCE_BITS-1:0]    rsp_force_q16_ff, rsp_force_q16_in;

   logic                     req_fire;
   logic [DATA_BITS-1:0]     word;
   logic [SUM_BITS-1:0]      sum_next;
   logic [COUNT_BITS-1:0]    words_next;
   logic [COUNT_BITS-1:0]    wanted;
   logic [DATA_BITS-1:0]     avg_q;
   logic [DATA_BITS-1:0]     mag;
   logic                     neg_avg;
   logic [FORCE_BITS-1:0]    q_ext;

   logic                     div_start;
   logic [DIV_BITS-1:0]      div_dividend;
   logic [DVSR_BITS-1:0]     div_divisor;
   logic                     div_done;
   logic [DIV_BITS-1:0]      div_quotient;

   lcar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == ST_READY);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      // words per sequence, clamped into 1..MAX_SAMPLES
      if (samples_ff == '0) begin
         wanted = COUNT_BITS'(1);
      end else if (SAMPLES_BITS'(samples_ff) > SAMPLES_BITS'(MAX_SAMPLES)) begin
         wanted = COUNT_BITS'(MAX_SAMPLES);
      end else begin
         wanted = COUNT_BITS'(samples_ff);
      end
      word       = shift_word_ff ^ {1'b1, {(DATA_BITS-1){1'b0}}};
      sum_next   = running_sum_ff + SUM_BITS'(word);
      words_next = words_taken_ff + 1'b1;
      avg_q      = div_quotient[DATA_BITS-1:0];
      neg_avg    = avg_q < tare_offset_ff;
      mag        = neg_avg ? (tare_offset_ff - avg_q) : (avg_q - tare_offset_ff);
      q_ext      = FORCE_BITS'(div_quotient);
   end

   always_comb begin
      state_in            = state_ff;
      phase_in            = phase_ff;
      clock_level_in      = clock_level_ff;
      bit_counter_in      = bit_counter_ff;
      shift_word_in       = shift_word_ff;
      running_sum_in      = running_sum_ff;
      words_taken_in      = words_taken_ff;
      pending_kind_in     = pending_kind_ff;
      tare_offset_in      = tare_offset_ff;
      samples_in          = samples_ff;
      scale_in            = scale_ff;
      neg_in              = neg_ff;
      avg_in              = avg_ff;
      rsp_serial_clock_in = rsp_serial_clock_ff;
      rsp_busy_res_in     = rsp_busy_res_ff;
      rsp_result_valid_in = rsp_result_valid_ff;
      rsp_result_kind_in  = rsp_result_kind_ff;
      rsp_average_raw_in  = rsp_average_raw_ff;
      rsp_force_q16_in    = rsp_force_q16_ff;
      div_start           = 1'b0;
      div_dividend        = DIV_BITS'(sum_next);
      div_divisor         = DVSR_BITS'(words_next);

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLES: samples_in = csr_data[SAMPLES_BITS-1:0];
            CSR_SCALE:   scale_in   = csr_data[SCALE_BITS-1:0];
            default:     ;
         endcase
      end

      case (state_ff)
         ST_READY: begin
            if (req_fire) begin
               // ordinary tick response unless the sequence completes below
               state_in            = ST_RESP;
               rsp_result_valid_in = 1'b0;
               rsp_result_kind_in  = 1'b0;
               rsp_average_raw_in  = '0;
               rsp_force_q16_in    = '0;
               case (phase_ff)
                  PH_IDLE: begin
                     clock_level_in = 1'b0;
                     if (req_mode == MODE_MEASURE || req_mode == MODE_TARE) begin
                        pending_kind_in = (req_mode == MODE_TARE);
                        running_sum_in  = '0;
                        words_taken_in  = '0;
                        bit_counter_in  = '0;
                        shift_word_in   = '0;
                        phase_in        = PH_WAIT;
                     end
                  end
                  PH_WAIT: begin
                     clock_level_in = 1'b0;
                     if (!req_data_level) begin
                        bit_counter_in = '0;
                        shift_word_in  = '0;
                        clock_level_in = 1'b1;
                        phase_in       = PH_BITS;
                     end
                  end
                  PH_BITS: begin
                     if (!clock_level_ff) begin
                        clock_level_in = 1'b1;
                     end else begin
                        shift_word_in  = {shift_word_ff[DATA_BITS-2:0], req_data_level};
                        clock_level_in = 1'b0;
                        bit_counter_in = bit_counter_ff + 1'b1;
                        if (bit_counter_in >= BIT_CNT_BITS'(DATA_BITS)) begin
                           phase_in = PH_GAIN;
                        end
                     end
                  end
                  PH_GAIN: begin
                     if (!clock_level_ff) begin
                        clock_level_in = 1'b1;
                     end else begin
                        clock_level_in = 1'b0;
                        shift_word_in  = word;
                        bit_counter_in = '0;
                        if (words_next >= wanted) begin
                           // sequence done: divide the full sum by the word count
                           running_sum_in = '0;
                           words_taken_in = '0;
                           phase_in       = PH_IDLE;
                           div_start      = 1'b1;
                           state_in       = ST_AVG;
                        end else begin
                           running_sum_in = sum_next;
                           words_taken_in = words_next;
                           phase_in       = PH_WAIT;
                        end
                     end
                  end
                  default: ;
               endcase
               rsp_serial_clock_in = clock_level_in;
               rsp_busy_res_in     = (phase_in != PH_IDLE);
            end
         end
         ST_AVG: begin
            if (div_done) begin
               avg_in = avg_q;
               if (pending_kind_ff) begin
                  tare_offset_in      = avg_q;
                  rsp_result_valid_in = 1'b1;
                  rsp_result_kind_in  = 1'b1;
                  rsp_average_raw_in  = avg_q;
                  rsp_force_q16_in    = '0;
                  state_in            = ST_RESP;
               end else begin
                  neg_in       = neg_avg;
                  div_start    = 1'b1;
                  div_dividend = DIV_BITS'(mag) << FRACTION_BITS;
                  div_divisor  = (scale_ff == '0) ? DVSR_BITS'(1) : DVSR_BITS'(scale_ff);
                  state_in     = ST_FORCE;
               end
            end
         end
         ST_FORCE: begin
            if (div_done) begin
               rsp_result_valid_in = 1'b1;
               rsp_result_kind_in  = 1'b0;
               rsp_average_raw_in  = avg_ff;
               rsp_force_q16_in    = neg_ff ? (FORCE_BITS'(0) - q_ext) : q_ext;
               state_in            = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_READY;
         phase_ff        <= PH_IDLE;
         clock_level_ff  <= 1'b0;
         bit_counter_ff  <= '0;
         shift_word_ff   <= '0;
         running_sum_ff  <= '0;
         words_taken_ff  <= '0;
         pending_kind_ff <= 1'b0;
         tare_offset_ff  <= '0;
         samples_ff      <= SAMPLES_RESET;
         scale_ff        <= SCALE_RESET;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         clock_level_ff  <= clock_level_in;
         bit_counter_ff  <= bit_counter_in;
         shift_word_ff   <= shift_word_in;
         running_sum_ff  <= running_sum_in;
         words_taken_ff  <= words_taken_in;
         pending_kind_ff <= pending_kind_in;
         tare_offset_ff  <= tare_offset_in;
         samples_ff      <= samples_in;
         scale_ff        <= scale_in;
      end
      neg_ff              <= neg_in;
      avg_ff              <= avg_in;
      rsp_serial_clock_ff <= rsp_serial_clock_in;
      rsp_busy_res_ff     <= rsp_busy_res_in;
      rsp_result_valid_ff <= rsp_result_valid_in;
      rsp_result_kind_ff  <= rsp_result_kind_in;
      rsp_average_raw_ff  <= rsp_average_raw_in;
      rsp_force_q16_ff    <= rsp_force_q16_in;
   end

   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_serial_clock = rsp_serial_clock_ff;
   assign rsp_busy_res     = rsp_busy_res_ff;
   assign rsp_result_valid = rsp_result_valid_ff;
   assign rsp_result_kind  = rsp_result_kind_ff;
   assign rsp_average_raw  = rsp_average_raw_ff;
   assign rsp_force_q16    = rsp_force_q16_ff;

endmodule

// ===== sv/lcar_div.sv =====
// ----------------------------------------------------------------------------
// lcar_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcar_div import lcar_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_BITS-1:0]  dividend,
   input  logic [DVSR_BITS-1:0] divisor,
   output logic                 done,
   output logic [DIV_BITS-1:0]  quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [DVSR_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]   quo_ff, quo_in;
   logic [DVSR_BITS-1:0]  dvsr_ff, dvsr_in;
   logic [DVSR_BITS:0]    partial;
   logic [DVSR_BITS+1:0]  diff;

   always_comb begin
      partial = {rem_ff, quo_ff[DIV_BITS-1]};
      diff    = {1'b0, partial} - {2'b00, dvsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         // borrow means the divisor does not fit: keep the partial remainder
         if (diff[DVSR_BITS+1]) begin
            rem_in = partial[DVSR_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end else begin
            rem_in = diff[DVSR_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
